@@ src/csr_sparse_matrix_vector_multiply_core_defines.svh @@
// Assertion macros for the sparse matrix-vector core checker.
// Included by the checker file; depends on nothing else.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication under a reset disable.
`define CSRSMV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csrsmv assertion failed");

// Next-cycle implication under a reset disable.
`define CSRSMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csrsmv assertion failed");

`endif

@@ src/csrsmv_pkg.sv @@
// Shared types and constants of the sparse matrix-vector core.
// Used by csrsmv_mac, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package csrsmv_pkg;

   localparam int DIM_MAX_DEF   = 64;
   localparam int NNZ_MAX_DEF   = 1024;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [2:0] {
      ACT_CLEAR    = 3'd0,
      ACT_ADD      = 3'd1,
      ACT_PACK     = 3'd2,
      ACT_LOAD     = 3'd3,
      ACT_MULTIPLY = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_PHASE = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EW,
      ST_SCAN_CW,
      ST_SWEEP,
      ST_SWEEP_TAIL,
      ST_MU_ROW,
      ST_MU_ROWD,
      ST_MU_ISS,
      ST_MU_DRAIN,
      ST_MU_FIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic clear;
   } mac_ctrl_type;

endpackage

@@ src/csrsmv_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
// Holds entries, accumulation cells and row descriptors; uses no package.
`timescale 1ns / 1ps

module csrsmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/csrsmv_vec_mem.sv @@
// Vector store: real and imaginary parts, one valid bit per element.
// An element never loaded reads as zero; uses no package.
`timescale 1ns / 1ps

module csrsmv_vec_mem #(
   parameter int DIM_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       we,
   input  logic [$clog2(DIM_MAX)-1:0] waddr,
   input  logic signed [31:0]         wre,
   input  logic signed [31:0]         wim,
   input  logic                       re,
   input  logic [$clog2(DIM_MAX)-1:0] raddr,
   output logic signed [31:0]         rre,
   output logic signed [31:0]         rim
);

   logic [63:0]        mem_ff [DIM_MAX];
   logic [DIM_MAX-1:0] valid_ff;
   logic [63:0]        rdata_ff;
   logic               rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= {wre, wim};
      end
      if (re) begin
         rdata_ff  <= mem_ff[raddr];
         rvalid_ff <= valid_ff[raddr];
      end
   end

   assign rre = rvalid_ff ? $signed(rdata_ff[63:32]) : 32'sd0;
   assign rim = rvalid_ff ? $signed(rdata_ff[31:0])  : 32'sd0;

endmodule

@@ src/csrsmv_mac.sv @@
// Complex multiply-accumulate of a real coefficient with a vector element,
// with floor shift and saturation to Q16.16. Uses csrsmv_pkg.
`timescale 1ns / 1ps

module csrsmv_mac #(
   parameter int FRAC_BITS = csrsmv_pkg::FRAC_BITS_DEF,
   parameter int ACC_W     = 75
) (
   input  logic                      clock,
   input  logic                      reset,
   input  csrsmv_pkg::mac_ctrl_type  ctrl,
   input  logic signed [31:0]        coef,
   input  logic signed [31:0]        vre,
   input  logic signed [31:0]        vim,
   output logic                      busy,
   output logic signed [31:0]        res_re,
   output logic signed [31:0]        res_im
);

   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32'sh7fffffff);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(32'sh80000000);

   logic signed [63:0]      prod_re_ff, prod_im_ff;
   logic                    prod_v_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic signed [ACC_W-1:0] sh_re, sh_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= coef * vre;
      prod_im_ff <= coef * vim;
      if (reset || ctrl.clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_v_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
      end
   end

   assign sh_re = acc_re_ff >>> FRAC_BITS;
   assign sh_im = acc_im_ff >>> FRAC_BITS;

   always_comb begin
      if (sh_re > ACC_MAX) begin
         res_re = 32'sh7fffffff;
      end else if (sh_re < ACC_MIN) begin
         res_re = 32'sh80000000;
      end else begin
         res_re = 32'(sh_re);
      end
      if (sh_im > ACC_MAX) begin
         res_im = 32'sh7fffffff;
      end else if (sh_im < ACC_MIN) begin
         res_im = 32'sh80000000;
      end else begin
         res_im = 32'(sh_im);
      end
   end

   assign busy = prod_v_ff;

endmodule

@@ src/csr_sparse_matrix_vector_multiply_core.sv @@
// Top level of the sparse matrix-vector core: sequencer, entry, cell,
// row and vector stores. Uses csrsmv_pkg, csrsmv_ram, csrsmv_vec_mem, csrsmv_mac.
//
//   channel  direction  handshake          payload
//   req      in         start, busy        action, row, column, value, vector
//   rsp      out        rsp_valid strobe   row, real, imag, status, last
//   csr      in         csr_valid, ready   dimension
//
// Clear, add, load and rejected items answer in the next cycle and the next
// item may follow right away. Pack sums entries into a cell sum memory by a scan
// of the entries (read, wait, cell write) and a sweep of DIM_MAX rows of cells
// (one a cycle) that compacts and clears them; multiply reads each row's
// descriptor and walks its entries one a cycle. After reset a clearing pass of the
// cell memory holds busy high. Results are strobes; the receiver cannot stall.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_core #(
   parameter int DIM_MAX   = csrsmv_pkg::DIM_MAX_DEF,
   parameter int NNZ_MAX   = csrsmv_pkg::NNZ_MAX_DEF,
   parameter int FRAC_BITS = csrsmv_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [5:0]         req_row_in,
   input  logic [5:0]         req_column,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_vec_real,
   input  logic signed [31:0] req_vec_imag,
   output logic               rsp_valid,
   output logic [5:0]         rsp_out_row,
   output logic signed [31:0] rsp_out_real,
   output logic signed [31:0] rsp_out_imag,
   output logic [1:0]         rsp_status,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_dimension
);

   localparam int IDX_W   = $clog2(DIM_MAX);
   localparam int EA_W    = $clog2(NNZ_MAX);
   localparam int CNT_W   = $clog2(NNZ_MAX + 1);
   localparam int CELL_AW = 2 * IDX_W;
   localparam int SUM_W   = 32 + $clog2(NNZ_MAX) + 1;
   localparam int ACC_W   = 64 + $clog2(NNZ_MAX) + 1;
   localparam int ENT_W   = 2 * IDX_W + 32;
   localparam int ROW_W   = 2 * CNT_W;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7fffffff);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(32'sh80000000);

   csrsmv_pkg::state_type state_ff, state_in;

   logic             phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [6:0]       dim_ff, dim_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] swr_ff, swr_in, swc_ff, swc_in;
   logic [IDX_W-1:0] svr_ff, svr_in, svc_ff, svc_in;
   logic             sv_ff, sv_in;
   logic [CELL_AW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] n_ff, n_in, rstart_ff, rstart_in, rlen_ff, rlen_in;
   logic             iss_v_ff, iss_v_in, vv_ff;
   logic signed [31:0] val1_ff;

   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [5:0]         rsp_row_ff, rsp_row_in;
   logic signed [31:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic             entry_we, entry_re;
   logic [EA_W-1:0]  entry_waddr, entry_raddr;
   logic [ENT_W-1:0] entry_wdata, entry_rdata;
   logic               cell_we, cell_re;
   logic [CELL_AW-1:0] cell_waddr, cell_raddr;
   logic [SUM_W:0]     cell_wdata, cell_rdata;
   logic             row_we, row_re;
   logic [IDX_W-1:0] row_waddr, row_raddr;
   logic [ROW_W-1:0] row_wdata, row_rdata;
   logic             vec_we;
   logic signed [31:0] vec_rre, vec_rim;
   csrsmv_pkg::mac_ctrl_type mac_ctrl;
   logic               mac_busy;
   logic signed [31:0] mac_re, mac_im;

   logic [IDX_W-1:0]   ent_row, ent_col;
   logic signed [31:0] ent_val;
   logic signed [SUM_W-1:0] cell_sum, merged_sum;
   logic signed [31:0] merged_sat;
   logic               keep;
   logic [CNT_W-1:0]   n_next, len_next;
   logic               row_last;

   assign ent_row  = entry_rdata[ENT_W-1 -: IDX_W];
   assign ent_col  = entry_rdata[IDX_W+31 -: IDX_W];
   assign ent_val  = $signed(entry_rdata[31:0]);
   assign cell_sum = $signed(cell_rdata[SUM_W-1:0]);
   assign merged_sum = cell_sum + SUM_W'(ent_val);

   // Saturation of a merged cell read back in the sweep.
   always_comb begin
      if (cell_sum > SUM_MAX) begin
         merged_sat = 32'sh7fffffff;
      end else if (cell_sum < SUM_MIN) begin
         merged_sat = 32'sh80000000;
      end else begin
         merged_sat = 32'(cell_sum);
      end
   end

   assign keep = sv_ff && cell_rdata[SUM_W] && (7'(svr_ff) < dim_ff) && (7'(svc_ff) < dim_ff);
   assign n_next   = keep ? n_ff + CNT_W'(1) : n_ff;
   assign len_next = keep ? rlen_ff + CNT_W'(1) : rlen_ff;
   assign row_last = (7'(i_ff) + 7'd1) == dim_ff;

   // Configuration: out-of-range dimensions are clamped on write.
   always_comb begin
      dim_in = dim_ff;
      if (csr_valid) begin
         if (csr_dimension == 7'd0) begin
            dim_in = 7'd1;
         end else if (csr_dimension > 7'(DIM_MAX)) begin
            dim_in = 7'(DIM_MAX);
         end else begin
            dim_in = csr_dimension;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csrsmv_pkg::ST_CLR;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         dim_ff       <= 7'(DIM_MAX);
         clr_ff       <= '0;
         sv_ff        <= 1'b0;
         iss_v_ff     <= 1'b0;
         vv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         dim_ff       <= dim_in;
         clr_ff       <= clr_in;
         sv_ff        <= sv_in;
         iss_v_ff     <= iss_v_in;
         vv_ff        <= iss_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      i_ff          <= i_in;
      swr_ff        <= swr_in;
      swc_ff        <= swc_in;
      svr_ff        <= svr_in;
      svc_ff        <= svc_in;
      n_ff          <= n_in;
      rstart_ff     <= rstart_in;
      rlen_ff       <= rlen_in;
      val1_ff       <= ent_val;
      rsp_row_ff    <= rsp_row_in;
      rsp_re_ff     <= rsp_re_in;
      rsp_im_ff     <= rsp_im_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      i_in          = i_ff;
      swr_in        = swr_ff;
      swc_in        = swc_ff;
      svr_in        = swr_ff;
      svc_in        = swc_ff;
      sv_in         = 1'b0;
      clr_in        = clr_ff;
      n_in          = n_ff;
      rstart_in     = rstart_ff;
      rlen_in       = rlen_ff;
      iss_v_in      = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_row_in    = 6'd0;
      rsp_re_in     = 32'sd0;
      rsp_im_in     = 32'sd0;
      rsp_status_in = csrsmv_pkg::STAT_OK;
      rsp_last_in   = 1'b1;
      entry_we      = 1'b0;
      entry_waddr   = count_ff[EA_W-1:0];
      entry_wdata   = {req_row_in[IDX_W-1:0], req_column[IDX_W-1:0], req_entry_value};
      entry_re      = 1'b0;
      entry_raddr   = k_ff[EA_W-1:0];
      cell_we       = 1'b0;
      cell_waddr    = clr_ff;
      cell_wdata    = '0;
      cell_re       = 1'b0;
      cell_raddr    = {ent_row, ent_col};
      row_we        = 1'b0;
      row_waddr     = svr_ff;
      row_wdata     = {rstart_ff, len_next};
      row_re        = 1'b0;
      row_raddr     = i_ff;
      vec_we        = 1'b0;
      mac_ctrl.clear = 1'b0;

      // Delayed half of the pack sweep: compact a cell and clear it behind.
      if (sv_ff) begin
         cell_we    = 1'b1;
         cell_waddr = {svr_ff, svc_ff};
         cell_wdata = '0;
         if (keep) begin
            entry_we    = 1'b1;
            entry_waddr = n_ff[EA_W-1:0];
            entry_wdata = {svr_ff, svc_ff, merged_sat};
         end
         n_in = n_next;
         if (svc_ff == {IDX_W{1'b1}}) begin
            row_we    = 1'b1;
            rstart_in = n_next;
            rlen_in   = '0;
         end else begin
            rlen_in = len_next;
         end
      end

      unique case (state_ff)
         csrsmv_pkg::ST_CLR: begin
            cell_we = 1'b1;
            clr_in  = clr_ff + CELL_AW'(1);
            if (clr_ff == {CELL_AW{1'b1}}) begin
               state_in = csrsmv_pkg::ST_IDLE;
            end
         end
         csrsmv_pkg::ST_IDLE: begin
            mac_ctrl.clear = 1'b1;
            if (start) begin
               rsp_valid_in = 1'b1;
               case (req_action)
                  csrsmv_pkg::ACT_CLEAR: begin
                     phase_in = 1'b0;
                     count_in = '0;
                  end
                  csrsmv_pkg::ACT_ADD: begin
                     if (phase_ff) begin
                        rsp_status_in = csrsmv_pkg::STAT_PHASE;
                     end else if (7'(req_row_in) >= dim_ff || 7'(req_column) >= dim_ff) begin
                        rsp_status_in = csrsmv_pkg::STAT_RANGE;
                     end else if (count_ff >= CNT_W'(NNZ_MAX)) begin
                        rsp_status_in = csrsmv_pkg::STAT_FULL;
                     end else begin
                        entry_we = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  csrsmv_pkg::ACT_PACK: begin
                     if (phase_ff) begin
                        rsp_status_in = csrsmv_pkg::STAT_PHASE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        k_in      = '0;
                        swr_in    = '0;
                        swc_in    = '0;
                        n_in      = '0;
                        rstart_in = '0;
                        rlen_in   = '0;
                        state_in  = (count_ff == '0) ? csrsmv_pkg::ST_SWEEP
                                                     : csrsmv_pkg::ST_SCAN_RD;
                     end
                  end
                  csrsmv_pkg::ACT_LOAD: begin
                     if (7'(req_row_in) >= dim_ff) begin
                        rsp_status_in = csrsmv_pkg::STAT_RANGE;
                     end else begin
                        vec_we = 1'b1;
                     end
                  end
                  csrsmv_pkg::ACT_MULTIPLY: begin
                     if (!phase_ff) begin
                        rsp_status_in = csrsmv_pkg::STAT_PHASE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        i_in     = '0;
                        state_in = csrsmv_pkg::ST_MU_ROW;
                     end
                  end
                  default: begin
                     rsp_status_in = csrsmv_pkg::STAT_PHASE;
                  end
               endcase
            end
         end
         csrsmv_pkg::ST_SCAN_RD: begin
            entry_re = 1'b1;
            state_in = csrsmv_pkg::ST_SCAN_EW;
         end
         csrsmv_pkg::ST_SCAN_EW: begin
            // Entries outside the current dimension are dropped here.
            if (7'(ent_row) < dim_ff && 7'(ent_col) < dim_ff) begin
               cell_re  = 1'b1;
               state_in = csrsmv_pkg::ST_SCAN_CW;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = (k_ff + CNT_W'(1) == count_ff) ? csrsmv_pkg::ST_SWEEP
                                                         : csrsmv_pkg::ST_SCAN_RD;
            end
         end
         csrsmv_pkg::ST_SCAN_CW: begin
            cell_we    = 1'b1;
            cell_waddr = {ent_row, ent_col};
            cell_wdata = {1'b1, merged_sum};
            k_in       = k_ff + CNT_W'(1);
            state_in   = (k_ff + CNT_W'(1) == count_ff) ? csrsmv_pkg::ST_SWEEP
                                                        : csrsmv_pkg::ST_SCAN_RD;
         end
         csrsmv_pkg::ST_SWEEP: begin
            cell_re    = 1'b1;
            cell_raddr = {swr_ff, swc_ff};
            sv_in      = 1'b1;
            swc_in     = swc_ff + IDX_W'(1);
            if (swc_ff == {IDX_W{1'b1}}) begin
               swr_in = swr_ff + IDX_W'(1);
               if (swr_ff == IDX_W'(DIM_MAX - 1)) begin
                  state_in = csrsmv_pkg::ST_SWEEP_TAIL;
               end
            end
         end
         csrsmv_pkg::ST_SWEEP_TAIL: begin
            count_in     = n_next;
            phase_in     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = csrsmv_pkg::ST_IDLE;
         end
         csrsmv_pkg::ST_MU_ROW: begin
            row_re   = 1'b1;
            state_in = csrsmv_pkg::ST_MU_ROWD;
         end
         csrsmv_pkg::ST_MU_ROWD: begin
            k_in     = row_rdata[ROW_W-1 -: CNT_W];
            rem_in   = row_rdata[CNT_W-1:0];
            state_in = (row_rdata[CNT_W-1:0] == '0) ? csrsmv_pkg::ST_MU_DRAIN
                                                    : csrsmv_pkg::ST_MU_ISS;
         end
         csrsmv_pkg::ST_MU_ISS: begin
            entry_re = 1'b1;
            iss_v_in = 1'b1;
            k_in     = k_ff + CNT_W'(1);
            rem_in   = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               state_in = csrsmv_pkg::ST_MU_DRAIN;
            end
         end
         csrsmv_pkg::ST_MU_DRAIN: begin
            if (!iss_v_ff && !vv_ff && !mac_busy) begin
               state_in = csrsmv_pkg::ST_MU_FIN;
            end
         end
         csrsmv_pkg::ST_MU_FIN: begin
            rsp_valid_in   = 1'b1;
            rsp_row_in     = 6'(i_ff);
            rsp_re_in      = mac_re;
            rsp_im_in      = mac_im;
            rsp_last_in    = row_last;
            mac_ctrl.clear = 1'b1;
            i_in           = i_ff + IDX_W'(1);
            state_in       = row_last ? csrsmv_pkg::ST_IDLE : csrsmv_pkg::ST_MU_ROW;
         end
         default: begin
            state_in = csrsmv_pkg::ST_IDLE;
         end
      endcase
   end

   assign mac_ctrl.valid = vv_ff;

   csrsmv_ram #(.WIDTH(ENT_W), .DEPTH(NNZ_MAX)) u_entry_ram (
      .clock (clock),
      .we    (entry_we),
      .waddr (entry_waddr),
      .wdata (entry_wdata),
      .re    (entry_re),
      .raddr (entry_raddr),
      .rdata (entry_rdata)
   );

   csrsmv_ram #(.WIDTH(SUM_W + 1), .DEPTH(1 << CELL_AW)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .re    (cell_re),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   csrsmv_ram #(.WIDTH(ROW_W), .DEPTH(DIM_MAX)) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .re    (row_re),
      .raddr (row_raddr),
      .rdata (row_rdata)
   );

   csrsmv_vec_mem #(.DIM_MAX(DIM_MAX)) u_vec_mem (
      .clock (clock),
      .reset (reset),
      .we    (vec_we),
      .waddr (req_row_in[IDX_W-1:0]),
      .wre   (req_vec_real),
      .wim   (req_vec_imag),
      .re    (iss_v_ff),
      .raddr (ent_col),
      .rre   (vec_rre),
      .rim   (vec_rim)
   );

   csrsmv_mac #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (val1_ff),
      .vre    (vec_rre),
      .vim    (vec_rim),
      .busy   (mac_busy),
      .res_re (mac_re),
      .res_im (mac_im)
   );

   assign busy         = state_ff != csrsmv_pkg::ST_IDLE;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_real = rsp_re_ff;
   assign rsp_out_imag = rsp_im_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ src/csrsmv_checker.sv @@
// Port-level checker of the sparse matrix-vector core, bound to the top.
// Uses the assertion macros of csr_sparse_matrix_vector_multiply_core_defines.svh.
`timescale 1ns / 1ps
`include "csr_sparse_matrix_vector_multiply_core_defines.svh"

module csrsmv_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_out_real,
   input logic signed [31:0] rsp_out_imag,
   input logic [1:0]         rsp_status,
   input logic               rsp_last
);

   // A failed item gives one result with zero data.
   `CSRSMV_ASSERT_IMPLY(a_err_single, clock, reset, rsp_valid && rsp_status != 2'd0, rsp_last && rsp_out_real == 32'sd0 && rsp_out_imag == 32'sd0)

   // While more results of a multiply are due, no new transfer is taken.
   `CSRSMV_ASSERT_IMPLY(a_more_busy, clock, reset, rsp_valid && !rsp_last, busy)

   // Busy rises only after an accepted item.
   `CSRSMV_ASSERT_IMPLY(a_busy_cause, clock, reset, $rose(busy), $past(start))

endmodule

bind csr_sparse_matrix_vector_multiply_core csrsmv_checker u_csrsmv_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_out_real (rsp_out_real),
   .rsp_out_imag (rsp_out_imag),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);

@@ tb/csr_sparse_matrix_vector_multiply_core_tb.sv @@
// Self-checking testbench for the CSR sparse matrix-vector multiply core.
// Depends on csrsmv_pkg and the core; it predicts every result internally.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_core_tb;
   import csrsmv_pkg::*;

   localparam int DIMS = 64;
   localparam int NNZ  = 1024;
   localparam logic [2:0] FIRST_UNUSED_ACTION = 3'd5;
   localparam logic [2:0] LAST_UNUSED_ACTION  = 3'd7;
   localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
   localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

   typedef struct {
      logic [2:0]  act;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [31:0] val;
      logic [31:0] vr;
      logic [31:0] vi;
   } command_t;

   typedef struct {
      logic [5:0]  row;
      logic [31:0] re;
      logic [31:0] im;
      logic [1:0]  st;
      logic        last;
   } product_t;

   // One row of the directed table: either a dimension write or a command,
   // optionally with a typed status for a single-result answer.
   typedef struct {
      bit          is_cfg;
      logic [6:0]  dim_value;
      command_t    cmd;
      bit          typed;
      status_type  typed_status;
   } script_row_t;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_action;
   logic [5:0] req_row_in;
   logic [5:0] req_column;
   logic signed [31:0] req_entry_value;
   logic signed [31:0] req_vec_real;
   logic signed [31:0] req_vec_imag;
   logic rsp_valid;
   logic [5:0] rsp_out_row;
   logic signed [31:0] rsp_out_real;
   logic signed [31:0] rsp_out_imag;
   logic [1:0] rsp_status;
   logic rsp_last;
   logic csr_valid;
   logic csr_ready;
   logic [6:0] csr_dimension;

   csr_sparse_matrix_vector_multiply_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_row_in(req_row_in), .req_column(req_column),
      .req_entry_value(req_entry_value), .req_vec_real(req_vec_real),
      .req_vec_imag(req_vec_imag), .rsp_valid(rsp_valid), .rsp_out_row(rsp_out_row),
      .rsp_out_real(rsp_out_real), .rsp_out_imag(rsp_out_imag),
      .rsp_status(rsp_status), .rsp_last(rsp_last), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_dimension(csr_dimension)
   );

   always #10 clock = ~clock;

   // Shadow copy of the matrix and vector state.
   int unsigned mdim;
   bit          is_packed;
   int          entry_total;
   logic [5:0]  ent_row [NNZ];
   logic [5:0]  ent_col [NNZ];
   int          ent_val [NNZ];
   int          row_first [DIMS];
   int          row_count [DIMS];
   int          vec_re [DIMS];
   int          vec_im [DIMS];

   product_t pending_products[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int multiplies_done = 0;
   int packs_done = 0;

   function automatic logic [31:0] saturate_q(logic signed [127:0] acc);
      logic signed [127:0] sh;
      sh = acc >>> 16;
      if (sh > Q_MAX) return 32'h7FFF_FFFF;
      if (sh < Q_MIN) return 32'h8000_0000;
      return sh[31:0];
   endfunction

   function automatic void set_dimension(logic [6:0] v);
      if (v == 0) mdim = 1;
      else if (v > DIMS) mdim = DIMS;
      else mdim = v;
   endfunction

   function automatic void push_status(status_type s);
      product_t p;
      p = '{row: '0, re: '0, im: '0, st: s, last: 1'b1};
      pending_products.push_back(p);
   endfunction

   function automatic void pack_matrix();
      longint cell_sum [DIMS][DIMS];
      bit     cell_hit [DIMS][DIMS];
      longint s;
      int n;
      for (int r = 0; r < DIMS; r++)
         for (int c = 0; c < DIMS; c++) begin
            cell_sum[r][c] = 0;
            cell_hit[r][c] = 0;
         end
      for (int k = 0; k < entry_total; k++)
         if (ent_row[k] < mdim && ent_col[k] < mdim) begin
            cell_sum[ent_row[k]][ent_col[k]] += longint'(ent_val[k]);
            cell_hit[ent_row[k]][ent_col[k]] = 1;
         end
      n = 0;
      for (int r = 0; r < DIMS; r++) begin
         row_first[r] = n;
         row_count[r] = 0;
         if (r < mdim)
            for (int c = 0; c < mdim; c++)
               if (cell_hit[r][c] && n < NNZ) begin
                  s = cell_sum[r][c];
                  if (s > 64'sd2147483647) s = 64'sd2147483647;
                  if (s < -64'sd2147483648) s = -64'sd2147483648;
                  ent_row[n] = r;
                  ent_col[n] = c;
                  ent_val[n] = int'(s);
                  n++;
                  row_count[r]++;
               end
      end
      entry_total = n;
   endfunction

   function automatic void predict_products(command_t c);
      logic signed [127:0] acc_re, acc_im;
      product_t p;
      int k;
      case (c.act)
         ACT_CLEAR: begin
            is_packed = 0;
            entry_total = 0;
            push_status(STAT_OK);
         end
         ACT_ADD: begin
            if (is_packed) push_status(STAT_PHASE);
            else if (c.row >= mdim || c.col >= mdim) push_status(STAT_RANGE);
            else if (entry_total >= NNZ) push_status(STAT_FULL);
            else begin
               ent_row[entry_total] = c.row;
               ent_col[entry_total] = c.col;
               ent_val[entry_total] = c.val;
               entry_total++;
               push_status(STAT_OK);
            end
         end
         ACT_PACK: begin
            if (is_packed) push_status(STAT_PHASE);
            else begin
               pack_matrix();
               is_packed = 1;
               push_status(STAT_OK);
            end
         end
         ACT_LOAD: begin
            if (c.row >= mdim) push_status(STAT_RANGE);
            else begin
               vec_re[c.row] = c.vr;
               vec_im[c.row] = c.vi;
               push_status(STAT_OK);
            end
         end
         ACT_MULTIPLY: begin
            if (!is_packed) push_status(STAT_PHASE);
            else begin
               for (int i = 0; i < mdim; i++) begin
                  acc_re = 0;
                  acc_im = 0;
                  for (int j = 0; j < row_count[i]; j++) begin
                     k = row_first[i] + j;
                     if (k >= entry_total) break;
                     acc_re += longint'(ent_val[k]) * longint'(vec_re[ent_col[k]]);
                     acc_im += longint'(ent_val[k]) * longint'(vec_im[ent_col[k]]);
                  end
                  p.row = i;
                  p.re = saturate_q(acc_re);
                  p.im = saturate_q(acc_im);
                  p.st = STAT_OK;
                  p.last = (i + 1 == mdim);
                  pending_products.push_back(p);
               end
            end
         end
         default: push_status(STAT_PHASE);
      endcase
   endfunction

   // Compare each strobed result against the oldest expectation.
   always @(posedge clock) begin
      product_t e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_products.size() == 0) begin
            errors++;
            $display("%0t: unexpected result row %0d status %0d", $time, rsp_out_row,
                     rsp_status);
         end else begin
            e = pending_products.pop_front();
            if (rsp_out_row !== e.row) begin
               errors++;
               $display("%0t: row expected %0d actual %0d", $time, e.row, rsp_out_row);
            end
            if (rsp_out_real !== e.re) begin
               errors++;
               $display("%0t: real expected %h actual %h", $time, e.re, rsp_out_real);
            end
            if (rsp_out_imag !== e.im) begin
               errors++;
               $display("%0t: imag expected %h actual %h", $time, e.im, rsp_out_imag);
            end
            if (rsp_status !== e.st) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, e.st, rsp_status);
            end
            if (rsp_last !== e.last) begin
               errors++;
               $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_last);
            end
         end
      end
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] random_q();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      if (r < 6) return 32'h7FFF_FFFF;
      if (r < 7) return 32'h8000_0000;
      return $urandom();
   endfunction

   // Holds start low for the given number of cycles; called at the edge of
   // the last transfer so start drops without a second assignment.
   task automatic idle_for(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_command(command_t c, int gap, bit typed, status_type ts);
      if (gap > 0) idle_for(gap);
      start <= 1'b1;
      req_action <= c.act;
      req_row_in <= c.row;
      req_column <= c.col;
      req_entry_value <= c.val;
      req_vec_real <= c.vr;
      req_vec_imag <= c.vi;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      items_sent++;
      if (c.act == ACT_MULTIPLY) multiplies_done++;
      if (c.act == ACT_PACK) packs_done++;
      if (typed) begin
         predict_products(c);
         void'(pending_products.pop_back());
         push_status(ts);
      end else begin
         predict_products(c);
      end
   endtask

   task automatic wait_all_products();
      idle_for(0);
      while (pending_products.size() > 0) @(posedge clock);
   endtask

   task automatic write_dimension(logic [6:0] v);
      wait_all_products();
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_dimension <= v;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      set_dimension(v);
   endtask

   task automatic send_random(logic [2:0] act, bit burst);
      command_t c;
      c.act = act;
      c.row = ($urandom_range(0, 99) < 88) ? 6'($urandom_range(0, mdim - 1))
                                             : 6'($urandom_range(0, 63));
      c.col = ($urandom_range(0, 99) < 88) ? 6'($urandom_range(0, mdim - 1))
                                             : 6'($urandom_range(0, 63));
      c.val = random_q();
      c.vr = random_q();
      c.vi = ($urandom_range(0, 3) == 0) ? 32'h0 : random_q();
      send_command(c, burst ? 0 : random_gap(), 0, STAT_OK);
   endtask

   script_row_t script [] = '{
      '{0, 0, '{ACT_MULTIPLY, 0, 0, 0, 0, 0}, 1, STAT_PHASE},
      '{0, 0, '{FIRST_UNUSED_ACTION, 63, 63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
        1, STAT_PHASE},
      '{0, 0, '{3'd6, 0, 0, 0, 0, 0}, 1, STAT_PHASE},
      '{0, 0, '{LAST_UNUSED_ACTION, 0, 0, 0, 0, 0}, 1, STAT_PHASE},
      '{0, 0, '{ACT_ADD, 0, 0, 32'h7FFFFFFF, 0, 0}, 1, STAT_OK},
      '{0, 0, '{ACT_ADD, 0, 0, 32'h7FFFFFFF, 0, 0}, 1, STAT_OK},
      '{0, 0, '{ACT_ADD, 63, 63, 32'h80000000, 0, 0}, 1, STAT_OK},
      '{0, 0, '{ACT_ADD, 5, 3, 32'h00010000, 0, 0}, 0, STAT_OK},
      '{0, 0, '{ACT_ADD, 5, 1, 32'hFFFE8000, 0, 0}, 0, STAT_OK},
      '{0, 0, '{ACT_LOAD, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000}, 1, STAT_OK},
      '{0, 0, '{ACT_LOAD, 63, 0, 0, 32'h80000000, 32'h7FFFFFFF}, 1, STAT_OK},
      '{0, 0, '{ACT_LOAD, 1, 0, 0, 32'h00010000, 0}, 0, STAT_OK},
      '{0, 0, '{ACT_LOAD, 3, 0, 0, 32'h00028000, 32'hFFFF0000}, 0, STAT_OK},
      '{0, 0, '{ACT_PACK, 0, 0, 0, 0, 0}, 1, STAT_OK},
      '{0, 0, '{ACT_PACK, 0, 0, 0, 0, 0}, 1, STAT_PHASE},
      '{0, 0, '{ACT_ADD, 1, 1, 32'h10000, 0, 0}, 1, STAT_PHASE},
      '{0, 0, '{ACT_MULTIPLY, 0, 0, 0, 0, 0}, 0, STAT_OK},
      '{0, 0, '{ACT_CLEAR, 0, 0, 0, 0, 0}, 1, STAT_OK},
      '{0, 0, '{ACT_ADD, 40, 2, 32'h00020000, 0, 0}, 1, STAT_OK},
      '{0, 0, '{ACT_ADD, 2, 2, 32'h00030000, 0, 0}, 1, STAT_OK},
      '{1, 7'd4, '{ACT_CLEAR, 0, 0, 0, 0, 0}, 0, STAT_OK},
      '{0, 0, '{ACT_ADD, 4, 0, 32'h10000, 0, 0}, 1, STAT_RANGE},
      '{0, 0, '{ACT_ADD, 0, 4, 32'h10000, 0, 0}, 1, STAT_RANGE},
      '{0, 0, '{ACT_LOAD, 4, 0, 0, 32'h10000, 0}, 1, STAT_RANGE},
      '{0, 0, '{ACT_PACK, 0, 0, 0, 0, 0}, 1, STAT_OK},
      '{1, 7'd0, '{ACT_CLEAR, 0, 0, 0, 0, 0}, 0, STAT_OK},
      '{1, 7'd127, '{ACT_CLEAR, 0, 0, 0, 0, 0}, 0, STAT_OK},
      '{0, 0, '{ACT_MULTIPLY, 0, 0, 0, 0, 0}, 0, STAT_OK}
   };

   initial begin
      command_t c;
      int sets;
      bit burst;
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_CLEAR;
      req_row_in = '0;
      req_column = '0;
      req_entry_value = '0;
      req_vec_real = '0;
      req_vec_imag = '0;
      csr_valid = 1'b0;
      csr_dimension = '0;
      mdim = DIMS;
      is_packed = 0;
      entry_total = 0;
      for (int i = 0; i < DIMS; i++) begin
         vec_re[i] = 0;
         vec_im[i] = 0;
         row_first[i] = 0;
         row_count[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg) write_dimension(script[i].dim_value);
         else send_command(script[i].cmd, random_gap(), script[i].typed,
                           script[i].typed_status);
      end

      // Fill the entry store to the brim, overflow it once, then use it.
      write_dimension(7'd64);
      send_random(ACT_CLEAR, 1);
      repeat (NNZ + 1) begin
         c = '{ACT_ADD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
               random_q(), 0, 0};
         send_command(c, ($urandom_range(0, 19) == 0) ? random_gap() : 0, 0, STAT_OK);
      end
      send_random(ACT_PACK, 0);
      send_random(ACT_MULTIPLY, 0);
      wait_all_products();
      items_sent = 0;

      sets = 0;
      while (items_sent < 180) begin
         if ($urandom_range(0, 2) == 0 || sets == 0)
            case ($urandom_range(0, 7))
               0: write_dimension(7'd1);
               1: write_dimension(7'd64);
               2: write_dimension(7'($urandom_range(65, 127)));
               3: write_dimension(7'($urandom_range(1, 64)));
               default: write_dimension(7'($urandom_range(2, 8)));
            endcase
         sets++;
         burst = ($urandom_range(0, 3) == 0);
         send_random(ACT_CLEAR, burst);
         repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 3) == 0) send_random(ACT_LOAD, burst);
            else send_random(ACT_ADD, burst);
         end
         if ($urandom_range(0, 5) == 0)
            send_random(3'($urandom_range(FIRST_UNUSED_ACTION, LAST_UNUSED_ACTION)), burst);
         if ($urandom_range(0, 5) == 0) send_random(ACT_MULTIPLY, burst);
         if ($urandom_range(0, 7) == 0)
            write_dimension(7'($urandom_range(1, 64)));
         send_random(ACT_PACK, burst);
         if ($urandom_range(0, 4) == 0) send_random(ACT_PACK, burst);
         if ($urandom_range(0, 4) == 0) send_random(ACT_ADD, burst);
         repeat ($urandom_range(0, 3)) send_random(ACT_LOAD, burst);
         if ($urandom_range(0, 4) == 0)
            write_dimension(7'($urandom_range(1, 64)));
         send_random(ACT_MULTIPLY, burst);
         if ($urandom_range(0, 2) == 0) send_random(ACT_MULTIPLY, burst);
         if ($urandom_range(0, 5) == 0) wait_all_products();
      end

      wait_all_products();
      repeat (50) @(posedge clock);
      $display("Covered %0d matrix sets, %0d packs and %0d multiplies; %0d results checked.",
               sets, packs_done, multiplies_done, results_seen);
      if (errors == 0 && pending_products.size() == 0)
         $display("csr_sparse_matrix_vector_multiply_core_tb: clean");
      else
         $display("csr_sparse_matrix_vector_multiply_core_tb: errors");
      $finish;
   end

   initial begin
      #40ms;
      $display("Timed out with %0d results still outstanding.", pending_products.size());
      $display("csr_sparse_matrix_vector_multiply_core_tb: errors");
      $finish;
   end

endmodule

@@ csr_sparse_matrix_vector_multiply_core.f @@
+incdir+src
src/csrsmv_pkg.sv
src/csrsmv_ram.sv
src/csrsmv_vec_mem.sv
src/csrsmv_mac.sv
src/csr_sparse_matrix_vector_multiply_core.sv
src/csrsmv_checker.sv
tb/csr_sparse_matrix_vector_multiply_core_tb.sv
